// ===== design/rngalloc_pkg.sv =====
// Shared types and codes for the first-fit range allocator.
// Depends on nothing; imported by the table memory and the top level.
package rngalloc_pkg;

  localparam int StartW = 12;
  localparam int LenW   = 13;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

  typedef struct packed {
    logic              func;
    logic [StartW-1:0] first_slot;
    logic [LenW-1:0]   slot_count;
  } alloc_req_t;

  typedef struct packed {
    logic [StartW-1:0] granted_start;
    logic [LenW-1:0]   granted_count;
    logic [1:0]        status;
  } alloc_rsp_t;

  typedef struct packed {
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
  } range_entry_t;

endpackage

// ===== design/first_fit_range_allocator_core.sv =====
// Top level of the first-fit slot range allocator with coalescing on free.
// Depends on rngalloc_pkg and instantiates rngalloc_table_ram.

// The block keeps the free slots of a pool as a table of ranges sorted by
// start slot, held in a single-port-write, registered-read memory. Requests
// are handled one at a time. An allocate reads the table from entry 0, one
// entry per cycle, until a range of at least the requested count turns up;
// it takes the slots from that range's front and, when the range empties,
// shifts the later entries down by one. A free scans for its position in
// start order, merges with the range before it, the range after it, or
// both, and otherwise shifts the later entries up to open a slot, or
// reports the table full when no slot is left. A shift touches only the
// entries from the one where the scan stopped to the end of the table. A
// result that still waits in the output register holds the next request
// in its response state until it is taken. Exactly one result transfer
// follows each input transfer. After reset, and after every write of the
// pool size register, the block writes the single full range into the
// table in its INIT state and stalls input while it does so. A pool size
// above POOL_SIZE is clipped to POOL_SIZE, and a pool size of zero leaves
// the table empty.
module first_fit_range_allocator_core
  import rngalloc_pkg::*;
#(
  parameter int POOL_SIZE  = 4096,
  parameter int MAX_RANGES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  alloc_req_t      in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output alloc_rsp_t      out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [LenW-1:0] cfg_data
);

  // Index width addresses the table; count width also holds MAX_RANGES.
  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_RANGES);

  localparam int PoolCapInt = (POOL_SIZE < 8191) ? POOL_SIZE : 8191;
  localparam int PoolRstInt = (POOL_SIZE < 4096) ? POOL_SIZE : 4096;
  localparam logic [LenW-1:0] PoolCap = LenW'(PoolCapInt);
  localparam logic [LenW-1:0] PoolRst = LenW'(PoolRstInt);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_AUPD  = 8'b0000_1000,
    S_FDEC  = 8'b0001_0000,
    S_FMRG  = 8'b0010_0000,
    S_SHIFT = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  function automatic logic [LenW-1:0] sat_len(input logic [LenW:0] v);
    return v[LenW] ? {LenW{1'b1}} : v[LenW-1:0];
  endfunction

  state_t          state_r, state_nxt;
  logic [LenW-1:0] pool_r, pool_nxt;
  logic [CW-1:0]   n_r, n_nxt;        // ranges in use
  logic [CW-1:0]   k_r, k_nxt;        // next read address of a scan or shift
  logic [CW-1:0]   rem_r, rem_nxt;    // entries still to be read by a shift
  logic [CW-1:0]   pos_r, pos_nxt;    // entry found by the scan
  logic            pend_r, pend_nxt;  // a read issued last cycle is returning
  logic [IW-1:0]   pidx_r, pidx_nxt;  // address of the returning read
  logic            up_r, up_nxt;      // shift direction: up to insert
  logic            prev_v_r, prev_v_nxt;
  logic            cur_v_r, cur_v_nxt;
  range_entry_t    prev_r, prev_nxt;
  range_entry_t    cur_r, cur_nxt;
  logic [LenW-1:0] nl_r, nl_nxt;      // length after merging with the range before
  alloc_req_t      req_r, req_nxt;
  alloc_rsp_t      res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  alloc_rsp_t      out_data_r, out_data_nxt;

  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  range_entry_t    rd_data;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  range_entry_t    wr_data;

  rngalloc_table_ram #(
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Input is taken only in IDLE; a configuration write at the same edge wins.
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Arithmetic on the request and on the ranges next to the free position.
  logic [LenW:0] in_end, req_end, prev_end, merged_end, sum_prev, sum_cur, sum_nl;
  logic          scan_hit;

  assign in_end     = {2'b00, in_data.first_slot} + {1'b0, in_data.slot_count};
  assign req_end    = {2'b00, req_r.first_slot} + {1'b0, req_r.slot_count};
  assign prev_end   = {2'b00, prev_r.start} + {1'b0, prev_r.len};
  assign merged_end = {2'b00, prev_r.start} + {1'b0, nl_r};
  assign sum_prev   = {1'b0, prev_r.len} + {1'b0, req_r.slot_count};
  assign sum_cur    = {1'b0, cur_r.len} + {1'b0, req_r.slot_count};
  assign sum_nl     = {1'b0, nl_r} + {1'b0, cur_r.len};

  // An allocate stops on the first range long enough; a free stops on the
  // first range that starts at or after the freed start.
  assign scan_hit = pend_r &&
                    ((req_r.func == FUNC_ALLOC) ? (rd_data.len >= req_r.slot_count)
                                                : (rd_data.start >= req_r.first_slot));

  always_comb begin
    state_nxt     = state_r;
    pool_nxt      = pool_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    up_nxt        = up_r;
    prev_v_nxt    = prev_v_r;
    cur_v_nxt     = cur_v_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    nl_nxt        = nl_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = k_r[IW-1:0];
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_data;

    // The output register frees itself whenever its transfer completes.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_data.start = '0;
        wr_data.len   = pool_r;
        n_nxt         = (pool_r != '0) ? CW'(1) : '0;
        state_nxt     = S_IDLE;
      end

      S_IDLE: begin
        if (cfg_valid) begin
          pool_nxt  = (cfg_data > PoolCap) ? PoolCap : cfg_data;
          state_nxt = S_INIT;
        end else if (in_valid) begin
          req_nxt    = in_data;
          k_nxt      = '0;
          prev_v_nxt = 1'b0;
          cur_v_nxt  = 1'b0;
          res_nxt.granted_start = '0;
          res_nxt.granted_count = '0;
          if (in_data.func == FUNC_ALLOC) begin
            res_nxt.status = ST_ALLOC_FAIL;
            if (in_data.slot_count == '0 || in_data.slot_count > pool_r) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            res_nxt.status = ST_OK;
            // A free of nothing, or one reaching past the pool, is dropped.
            if (in_data.slot_count == '0 || in_end > {1'b0, pool_r}) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (pend_r && !scan_hit) begin
          prev_nxt   = rd_data;
          prev_v_nxt = 1'b1;
        end
        if (scan_hit) begin
          cur_nxt   = rd_data;
          cur_v_nxt = 1'b1;
          pos_nxt   = CW'(pidx_r);
          state_nxt = (req_r.func == FUNC_ALLOC) ? S_AUPD : S_FDEC;
        end else if (!pend_r && k_r == n_r) begin
          // Whole table seen: allocate fails, free goes after the last range.
          pos_nxt   = n_r;
          state_nxt = (req_r.func == FUNC_ALLOC) ? S_RESP : S_FDEC;
        end else if (k_r != n_r) begin
          rd_en    = 1'b1;
          rd_addr  = k_r[IW-1:0];
          pend_nxt = 1'b1;
          pidx_nxt = k_r[IW-1:0];
          k_nxt    = k_r + 1'b1;
        end
      end

      S_AUPD: begin
        res_nxt.granted_start = cur_r.start;
        res_nxt.granted_count = req_r.slot_count;
        res_nxt.status        = ST_OK;
        if (cur_r.len != req_r.slot_count) begin
          wr_en         = 1'b1;
          wr_addr       = pos_r[IW-1:0];
          wr_data.start = cur_r.start + req_r.slot_count[StartW-1:0];
          wr_data.len   = cur_r.len - req_r.slot_count;
          state_nxt     = S_RESP;
        end else begin
          // The range is used up: pull the later entries down over it.
          up_nxt    = 1'b0;
          rem_nxt   = n_r - pos_r - 1'b1;
          k_nxt     = pos_r + 1'b1;
          state_nxt = S_SHIFT;
        end
      end

      S_FDEC: begin
        if (prev_v_r && prev_end == {2'b00, req_r.first_slot}) begin
          nl_nxt    = sat_len(sum_prev);
          state_nxt = S_FMRG;
        end else if (cur_v_r && {2'b00, cur_r.start} == req_end) begin
          wr_en         = 1'b1;
          wr_addr       = pos_r[IW-1:0];
          wr_data.start = req_r.first_slot;
          wr_data.len   = sat_len(sum_cur);
          state_nxt     = S_RESP;
        end else if (n_r >= MaxCnt) begin
          res_nxt.status = ST_TABLE_FULL;
          state_nxt      = S_RESP;
        end else begin
          // New range of its own: open a slot at the free position.
          up_nxt    = 1'b1;
          rem_nxt   = n_r - pos_r;
          k_nxt     = n_r - 1'b1;
          state_nxt = S_SHIFT;
        end
      end

      S_FMRG: begin
        wr_en         = 1'b1;
        wr_addr       = IW'(pos_r - 1'b1);
        wr_data.start = prev_r.start;
        if (cur_v_r && {2'b00, cur_r.start} == merged_end) begin
          // The freed range bridges two ranges: fold the later one in too.
          wr_data.len = sat_len(sum_nl);
          up_nxt      = 1'b0;
          rem_nxt     = n_r - pos_r - 1'b1;
          k_nxt       = pos_r + 1'b1;
          state_nxt   = S_SHIFT;
        end else begin
          wr_data.len = nl_r;
          state_nxt   = S_RESP;
        end
      end

      S_SHIFT: begin
        // Reads and writes run one entry apart, so they never meet.
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = up_r ? IW'(pidx_r + 1'b1) : IW'(pidx_r - 1'b1);
          wr_data = rd_data;
        end
        if (rem_r != '0) begin
          rd_en    = 1'b1;
          rd_addr  = k_r[IW-1:0];
          pend_nxt = 1'b1;
          pidx_nxt = k_r[IW-1:0];
          rem_nxt  = rem_r - 1'b1;
          k_nxt    = up_r ? (k_r - 1'b1) : (k_r + 1'b1);
        end else if (!pend_r) begin
          if (up_r) begin
            wr_en         = 1'b1;
            wr_addr       = pos_r[IW-1:0];
            wr_data.start = req_r.first_slot;
            wr_data.len   = req_r.slot_count;
            n_nxt         = n_r + 1'b1;
          end else begin
            n_nxt = n_r - 1'b1;
          end
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pool_r      <= PoolRst;
      n_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_r      <= pool_nxt;
      n_r         <= n_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    rem_r      <= rem_nxt;
    pos_r      <= pos_nxt;
    pidx_r     <= pidx_nxt;
    up_r       <= up_nxt;
    prev_v_r   <= prev_v_nxt;
    cur_v_r    <= cur_v_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    nl_r       <= nl_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== design/rngalloc_table_ram.sv =====
// Free-range table storage: one write port and one registered read port.
// Depends on rngalloc_pkg for the table entry type.
module rngalloc_table_ram
  import rngalloc_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output range_entry_t             rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  range_entry_t             wr_data
);

  range_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
